### design/modified_utf7_name_decoder_defines.svh
// assertion macros used by the decoder back end (mu7_back)
// no dependencies
`ifndef MODIFIED_UTF7_NAME_DECODER_DEFINES_SVH
`define MODIFIED_UTF7_NAME_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MU7_CHECK_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mu7 same-cycle check failed");

// next-cycle implication, checked outside reset
`define MU7_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mu7 next-cycle check failed");

`endif

### design/mu7_pkg.sv
// shared types and constants of the modified utf-7 name decoder
// no dependencies
package mu7_pkg;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_of_name;
   } req_type;

   typedef struct packed {
      logic        unit_valid;
      logic [15:0] code_unit;
      logic        end_of_name;
      logic        malformed;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_AMP,
      OP_DASH,
      OP_DATA
   } op_class_type;

   // one classified character as it sits in the queue
   typedef struct packed {
      op_class_type op_class;
      logic [5:0]   sextet;
      logic [7:0]   char_code;
      logic         last;
   } op_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] s;
      s = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) s = 6'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) s = 6'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) s = 6'(c - 8'h30 + 8'd52);
      else if (c == CH_PLUS) s = 6'd62;
      else if (c == CH_COMMA) s = 6'd63;
      return s;
   endfunction

endpackage

### design/mu7_front.sv
// front end: accepts request words and classifies each character
// depends on mu7_pkg
module mu7_front import mu7_pkg::*; (
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   input  logic    queue_full,
   output logic    push,
   output op_type  push_op
);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_op.char_code = req_word.char_code;
      push_op.last      = req_word.last_of_name;
      push_op.sextet    = sextet_of(req_word.char_code);
      priority if (req_word.char_code == CH_AMP) begin
         push_op.op_class = OP_AMP;
      end else if (req_word.char_code == CH_DASH) begin
         push_op.op_class = OP_DASH;
      end else begin
         push_op.op_class = OP_DATA;
      end
   end

endmodule

### design/mu7_queue.sv
// short queue of classified characters between front and back
// depends on mu7_pkg
module mu7_queue import mu7_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type pop_op,
   output logic   full,
   output logic   not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type           mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_op    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### design/mu7_back.sv
// back end: shift state machine, byte pairing and response register
// depends on mu7_pkg and the assertion macro header
`include "modified_utf7_name_decoder_defines.svh"
module mu7_back import mu7_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    not_empty,
   input  op_type  pop_op,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic       in_shift_ff, in_shift_in;
   logic       shift_empty_ff, shift_empty_in;
   logic [5:0] acc_ff, acc_in;
   logic [2:0] bits_held_ff, bits_held_in;
   logic       pending_ff, pending_in;
   logic [7:0] high_byte_ff, high_byte_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   assign pop       = not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      logic [11:0] acc12;
      logic [3:0]  held;
      logic [2:0]  sh;
      logic [7:0]  byte_val;
      logic [15:0] pair;
      acc12    = {acc_ff, pop_op.sextet};
      held     = {1'b0, bits_held_ff} + 4'd6;
      sh       = held[2:0];
      byte_val = 8'(acc12 >> sh);
      pair     = {high_byte_ff, byte_val};

      in_shift_in    = in_shift_ff;
      shift_empty_in = shift_empty_ff;
      acc_in         = acc_ff;
      bits_held_in   = bits_held_ff;
      pending_in     = pending_ff;
      high_byte_in   = high_byte_ff;
      rsp_in.unit_valid  = 1'b0;
      rsp_in.code_unit   = 16'd0;
      rsp_in.end_of_name = pop_op.last;
      rsp_in.malformed   = 1'b0;

      if (!in_shift_ff) begin
         if (pop_op.op_class == OP_AMP) begin
            in_shift_in    = 1'b1;
            shift_empty_in = 1'b1;
            acc_in         = '0;
            bits_held_in   = '0;
            pending_in     = 1'b0;
            high_byte_in   = '0;
         end else begin
            rsp_in.unit_valid = 1'b1;
            rsp_in.code_unit  = {8'd0, pop_op.char_code};
         end
      end else begin
         unique case (pop_op.op_class)
            OP_AMP: begin
               // reopened shift
               rsp_in.malformed = 1'b1;
               shift_empty_in   = 1'b1;
               acc_in           = '0;
               bits_held_in     = '0;
               pending_in       = 1'b0;
               high_byte_in     = '0;
            end
            OP_DASH: begin
               if (shift_empty_ff) begin
                  rsp_in.unit_valid = 1'b1;
                  rsp_in.code_unit  = {8'd0, CH_AMP};
               end else if (pending_ff && high_byte_ff != 8'd0) begin
                  rsp_in.unit_valid = 1'b1;
                  rsp_in.code_unit  = {high_byte_ff, 8'd0};
               end
               in_shift_in    = 1'b0;
               shift_empty_in = 1'b1;
               acc_in         = '0;
               bits_held_in   = '0;
               pending_in     = 1'b0;
               high_byte_in   = '0;
            end
            default: begin
               shift_empty_in = 1'b0;
               if (held >= 4'd8) begin
                  bits_held_in = sh;
                  acc_in       = 6'(acc12 & ((12'd1 << sh) - 12'd1));
                  if (pending_ff) begin
                     pending_in   = 1'b0;
                     high_byte_in = '0;
                     if (pair != 16'd0) begin
                        rsp_in.unit_valid = 1'b1;
                        rsp_in.code_unit  = pair;
                     end
                  end else begin
                     pending_in   = 1'b1;
                     high_byte_in = byte_val;
                  end
               end else begin
                  bits_held_in = held[2:0];
                  acc_in       = acc12[5:0];
               end
            end
         endcase
      end

      if (pop_op.last) begin
         if (in_shift_in) begin
            rsp_in.malformed = 1'b1;
         end
         in_shift_in    = 1'b0;
         shift_empty_in = 1'b1;
         acc_in         = '0;
         bits_held_in   = '0;
         pending_in     = 1'b0;
         high_byte_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_shift_ff    <= 1'b0;
         shift_empty_ff <= 1'b1;
         acc_ff         <= '0;
         bits_held_ff   <= '0;
         pending_ff     <= 1'b0;
         high_byte_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            in_shift_ff    <= in_shift_in;
            shift_empty_ff <= shift_empty_in;
            acc_ff         <= acc_in;
            bits_held_ff   <= bits_held_in;
            pending_ff     <= pending_in;
            high_byte_ff   <= high_byte_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   `MU7_CHECK_NOW(a_unit_zero_when_invalid, clock, reset, rsp_valid_ff && !rsp_ff.unit_valid, rsp_ff.code_unit == 16'd0)
   `MU7_CHECK_NEXT(a_name_end_resets, clock, reset, pop && pop_op.last, !in_shift_ff && shift_empty_ff && bits_held_ff == 3'd0 && !pending_ff)
   `MU7_CHECK_NOW(a_bits_even, clock, reset, 1'b1, !bits_held_ff[0])
   `MU7_CHECK_NOW(a_idle_outside_shift, clock, reset, !in_shift_ff, shift_empty_ff && !pending_ff && bits_held_ff == 3'd0)

endmodule

### design/modified_utf7_name_decoder.sv
// top level of the modified utf-7 mailbox name decoder
// depends on mu7_pkg, mu7_front, mu7_queue and mu7_back
//
//   channel  direction  handshake             word type
//   req      in         req_valid/req_stall   req_type (char_code, last_of_name)
//   rsp      out        rsp_valid/rsp_stall   rsp_type (unit_valid, code_unit,
//                                             end_of_name, malformed)
//
// one character per cycle sustained while rsp_stall is low; each word gives exactly one response word
// an accepted word is written to the queue and then to the response register, from
// which it leaves on rsp when rsp_stall is low
// reset is synchronous and active high and returns the shift state to idle
// the queue lets the front keep taking words while a response waits on rsp_stall
// req_stall rises only once the queue is full
module modified_utf7_name_decoder import mu7_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   // front to queue
   logic   push;
   op_type push_op;
   // queue to back
   logic   pop;
   op_type pop_op;
   logic   queue_full;
   logic   queue_not_empty;

   // classify the incoming character (amp, dash or any other character as data)
   mu7_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op)
   );

   // decouples accept from the shift state machine
   mu7_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .pop_op    (pop_op),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   // shift tracking, bit collection, byte pairing and the response register
   mu7_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .pop_op    (pop_op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### sim/modified_utf7_name_decoder_test.sv
// self-checking testbench of the modified utf-7 mailbox name decoder
// depends on mu7_pkg and modified_utf7_name_decoder
// directed table, then random mailbox names, checked by table or inline decoder model
`timescale 1ns / 1ps

module modified_utf7_name_decoder_test;
   import mu7_pkg::*;

   localparam int N_ITEMS     = 1650;
   localparam int N_DIRECTED  = 24;
   localparam int HOLD_CYCLES = 200;
   localparam int MAX_SHOWN   = 10;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      rsp_type    want;
   } step_row_type;

   localparam rsp_type PREDICTED = '0;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   // expected response words, oldest first
   rsp_type pending_units[$];

   // decoder model state
   logic        sh_open;
   logic        sh_empty;
   logic [11:0] sh_bits;
   logic [3:0]  sh_count;
   logic        sh_hi_pend;
   logic [7:0]  sh_hi;

   int items_sent;
   int error_count;
   int tx_burst;
   int rx_burst;
   bit hold_rsp;
   bit pause_tx;

   // directed words: pass-through extremes, empty shift, lone high byte at close,
   // high character inside a shift, reopened shift, unterminated shift, name ends
   step_row_type directed [N_DIRECTED] = '{
      '{"A",      1'b0, 1'b1, '{1'b1, 16'h0041, 1'b0, 1'b0}},
      '{8'h00,    1'b0, 1'b1, '{1'b1, 16'h0000, 1'b0, 1'b0}},
      '{8'hFF,    1'b0, 1'b1, '{1'b1, 16'h00FF, 1'b0, 1'b0}},
      '{8'h80,    1'b0, 1'b1, '{1'b1, 16'h0080, 1'b0, 1'b0}},
      '{CH_AMP,   1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CH_DASH,  1'b0, 1'b1, '{1'b1, 16'h0026, 1'b0, 1'b0}},
      '{CH_AMP,   1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CH_COMMA, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CH_COMMA, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CH_DASH,  1'b0, 1'b1, '{1'b1, 16'hFF00, 1'b0, 1'b0}},
      '{CH_AMP,   1'b0, 1'b0, PREDICTED},
      '{"A",      1'b0, 1'b0, PREDICTED},
      '{"O",      1'b0, 1'b0, PREDICTED},
      '{"k",      1'b0, 1'b0, PREDICTED},
      '{"9",      1'b0, 1'b0, PREDICTED},
      '{CH_PLUS,  1'b0, 1'b0, PREDICTED},
      '{"z",      1'b0, 1'b0, PREDICTED},
      '{CH_DASH,  1'b0, 1'b0, PREDICTED},
      '{CH_AMP,   1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
      '{8'hC3,    1'b0, 1'b0, PREDICTED},
      '{CH_AMP,   1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
      '{"Q",      1'b1, 1'b0, PREDICTED},
      '{CH_AMP,   1'b1, 1'b1, '{1'b0, 16'h0000, 1'b1, 1'b1}},
      '{CH_DASH,  1'b1, 1'b1, '{1'b1, 16'h002D, 1'b1, 1'b0}}
   };

   modified_utf7_name_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // modified base64 value of a character, zero outside the alphabet
   function automatic logic [5:0] b64_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return 6'(c - "A");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
      if (c == CH_PLUS) return 6'd62;
      if (c == CH_COMMA) return 6'd63;
      return 6'd0;
   endfunction

   function automatic logic [7:0] b64_symbol(input int v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return CH_PLUS;
      return CH_COMMA;
   endfunction

   function automatic void clear_shift();
      sh_empty   = 1'b1;
      sh_bits    = '0;
      sh_count   = '0;
      sh_hi_pend = 1'b0;
      sh_hi      = '0;
   endfunction

   // advance the decoder model by one character and return its response word
   function automatic rsp_type decode_char(input req_type w);
      rsp_type     r;
      logic [17:0] acc;
      int          held;
      int          sh;
      logic [7:0]  b;
      logic [15:0] u;
      r = '0;
      r.end_of_name = w.last_of_name;
      if (!sh_open) begin
         if (w.char_code == CH_AMP) begin
            sh_open = 1'b1;
            clear_shift();
         end else begin
            r.unit_valid = 1'b1;
            r.code_unit  = {8'h00, w.char_code};
         end
      end else if (w.char_code == CH_AMP) begin
         // reopen inside a shift drops partial data
         r.malformed = 1'b1;
         clear_shift();
      end else if (w.char_code == CH_DASH) begin
         if (sh_empty) begin
            r.unit_valid = 1'b1;
            r.code_unit  = {8'h00, CH_AMP};
         end else if (sh_hi_pend && sh_hi != 8'h00) begin
            r.unit_valid = 1'b1;
            r.code_unit  = {sh_hi, 8'h00};
         end
         sh_open = 1'b0;
         clear_shift();
      end else begin
         acc  = {sh_bits, 6'b0} | 18'(b64_value(w.char_code));
         held = int'(sh_count) + 6;
         sh_empty = 1'b0;
         if (held >= 8) begin
            sh   = held - 8;
            b    = 8'(acc >> sh);
            held = sh;
            acc  = acc & ((18'd1 << sh) - 18'd1);
            if (sh_hi_pend) begin
               u          = {sh_hi, b};
               sh_hi_pend = 1'b0;
               sh_hi      = '0;
               // zero units are dropped
               if (u != 16'h0000) begin
                  r.unit_valid = 1'b1;
                  r.code_unit  = u;
               end
            end else begin
               sh_hi_pend = 1'b1;
               sh_hi      = b;
            end
         end
         sh_bits  = acc[11:0];
         sh_count = 4'(held);
      end
      if (w.last_of_name) begin
         if (sh_open) r.malformed = 1'b1;
         sh_open = 1'b0;
         clear_shift();
      end
      return r;
   endfunction

   // idle cycles before the next word, with bursts of back-to-back words
   function automatic int next_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // offer one word, wait for it to be taken, then record what should come back
   task automatic offer_char(input logic [7:0] ch, input logic last, input logic typed,
                             input rsp_type want);
      int      gap;
      req_type w;
      rsp_type predicted;
      gap = next_wait(tx_burst);
      w.char_code    = ch;
      w.last_of_name = last;
      if (gap > 0 || pause_tx) begin
         req_valid <= 1'b0;
         if (pause_tx) begin
            // let the block run dry before going on
            @(posedge clock);
            while (pending_units.size() != 0) @(posedge clock);
            pause_tx = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = decode_char(w);
      pending_units.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // one random mailbox name: mostly well formed, some noise, some broken shifts
   task automatic send_random_name();
      logic [7:0] name_chars[$];
      int         kind;
      int         nseg;
      int         len;
      logic [7:0] c;
      kind = $urandom_range(0, 15);
      if (kind >= 12 && kind <= 13) begin
         len = $urandom_range(1, 12);
         repeat (len) name_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         nseg = $urandom_range(1, 4);
         repeat (nseg) begin
            if ($urandom_range(0, 2) == 0) begin
               len = $urandom_range(1, 4);
               repeat (len) begin
                  c = 8'($urandom_range(0, 255));
                  if (c == CH_AMP) c = c ^ 8'h01;
                  name_chars.push_back(c);
               end
            end else begin
               name_chars.push_back(CH_AMP);
               len = $urandom_range(0, 8);
               repeat (len) begin
                  if (kind == 15 && $urandom_range(0, 3) == 0) name_chars.push_back(CH_AMP);
                  if ($urandom_range(0, 15) == 0) begin
                     // stray character inside the shift counts as zero
                     c = 8'($urandom_range(0, 255));
                     if (c == CH_AMP || c == CH_DASH) c = 8'hC0;
                  end else begin
                     c = b64_symbol($urandom_range(0, 63));
                  end
                  name_chars.push_back(c);
               end
               name_chars.push_back(CH_DASH);
            end
         end
         if (kind == 14) begin
            // shift left open at the end of the name
            name_chars.push_back(CH_AMP);
            len = $urandom_range(0, 3);
            repeat (len) name_chars.push_back(b64_symbol($urandom_range(0, 63)));
         end
      end
      foreach (name_chars[i])
         offer_char(name_chars[i], i == name_chars.size() - 1, 1'b0, PREDICTED);
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            n = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            n = next_wait(rx_burst);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // scoreboard: every accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_units.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("unexpected word: valid=%0b unit=%h end=%0b bad=%0b",
                        rsp_word.unit_valid, rsp_word.code_unit,
                        rsp_word.end_of_name, rsp_word.malformed);
         end else begin
            want = pending_units.pop_front();
            if (rsp_word.unit_valid !== want.unit_valid ||
                rsp_word.code_unit !== want.code_unit ||
                rsp_word.end_of_name !== want.end_of_name ||
                rsp_word.malformed !== want.malformed) begin
               error_count++;
               if (error_count <= MAX_SHOWN)
                  $display("mismatch: expected %0b/%h/%0b/%0b got %0b/%h/%0b/%0b",
                           want.unit_valid, want.code_unit,
                           want.end_of_name, want.malformed,
                           rsp_word.unit_valid, rsp_word.code_unit,
                           rsp_word.end_of_name, rsp_word.malformed);
            end
         end
      end
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // stimulus
   initial begin
      bit held_off;
      bit paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      items_sent  = 0;
      error_count = 0;
      tx_burst    = 0;
      rx_burst    = 0;
      hold_rsp    = 1'b0;
      pause_tx    = 1'b0;
      held_off    = 1'b0;
      paused      = 1'b0;
      sh_open     = 1'b0;
      clear_shift();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         offer_char(directed[i].ch, directed[i].last, directed[i].typed, directed[i].want);

      while (items_sent < N_ITEMS) begin
         // long receiver hold-off to fill the queue and push back on requests
         if (!held_off && items_sent >= 400) begin
            hold_rsp = 1'b1;
            held_off = 1'b1;
         end
         // sender waits for the block to drain completely
         if (!paused && items_sent >= 900) begin
            pause_tx = 1'b1;
            paused   = 1'b1;
         end
         send_random_name();
      end
      req_valid <= 1'b0;

      while (pending_units.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_units.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
